[rtl/mror_pkg.sv]
`timescale 1ns / 1ps

package mror_pkg;

	// operation codes as they arrive on the item channel
	localparam logic [2:0] OP_WRITE  = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_ATTACH = 3'd2;
	localparam logic [2:0] OP_DETACH = 3'd3;
	localparam logic [2:0] OP_EOF    = 3'd4;
	localparam logic [2:0] OP_QUERY  = 3'd5;

	// result status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_NO_DATA = 3'd1;
	localparam logic [2:0] STAT_EOS     = 3'd2;
	localparam logic [2:0] STAT_NO_FREE = 3'd3;
	localparam logic [2:0] STAT_NOT_FND = 3'd4;

	typedef enum logic [2:0] {
		K_WRITE,
		K_READ,
		K_ATTACH,
		K_DETACH,
		K_EOF,
		K_QUERY,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] slot;
		logic       slot_ok;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

[rtl/mror_ram.sv]
`timescale 1ns / 1ps

module mror_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/mror_front.sv]
`timescale 1ns / 1ps

// Takes items, decodes them into commands and holds them in a two-word queue.
module mror_front #(
	parameter int READERS    = 4,
	parameter int DATA_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [2:0]            operation,
	input  logic [1:0]            reader_slot,
	input  logic [DATA_WIDTH-1:0] write_data,
	output mror_pkg::head_t       head,
	output logic [DATA_WIDTH-1:0] head_data,
	input  logic                  pop
);

	mror_pkg::cmd_t        dec;
	mror_pkg::cmd_t        cmd_q  [2];
	logic [DATA_WIDTH-1:0] data_q [2];
	logic                  rd_q;
	logic                  wr_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic                  do_pop;

	always_comb begin
		case (operation)
			mror_pkg::OP_WRITE:  dec.kind = mror_pkg::K_WRITE;
			mror_pkg::OP_READ:   dec.kind = mror_pkg::K_READ;
			mror_pkg::OP_ATTACH: dec.kind = mror_pkg::K_ATTACH;
			mror_pkg::OP_DETACH: dec.kind = mror_pkg::K_DETACH;
			mror_pkg::OP_EOF:    dec.kind = mror_pkg::K_EOF;
			mror_pkg::OP_QUERY:  dec.kind = mror_pkg::K_QUERY;
			default:             dec.kind = mror_pkg::K_NOP;
		endcase
		dec.slot    = reader_slot;
		dec.slot_ok = 32'(reader_slot) < 32'(READERS);
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign do_pop     = pop && (cnt_q != 2'd0);

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = cmd_q[rd_q];
	assign head_data  = data_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_q]  <= dec;
			data_q[wr_q] <= write_data;
		end
	end

endmodule

[rtl/mror_back.sv]
`timescale 1ns / 1ps

// Executes queued commands against the pointer state and drives the result register.
module mror_back #(
	parameter int CAPACITY   = 15,
	parameter int READERS    = 4,
	parameter int DATA_WIDTH = 8,
	localparam int SLOTS     = CAPACITY + 1,
	localparam int PW        = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mror_pkg::head_t       head,
	input  logic [DATA_WIDTH-1:0] head_data,
	output logic                  pop,
	output logic                  ram_we,
	output logic [PW-1:0]         ram_waddr,
	output logic [DATA_WIDTH-1:0] ram_wdata,
	output logic                  ram_re,
	output logic [PW-1:0]         ram_raddr,
	input  logic [DATA_WIDTH-1:0] ram_rdata,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [2:0]            status,
	output logic [DATA_WIDTH-1:0] read_data,
	output logic                  last,
	output logic [1:0]            assigned_slot,
	output logic                  is_empty,
	output logic [2:0]            reader_count,
	output logic                  overrun
);

	localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;

	typedef enum logic {
		S_IDLE,
		S_DRAIN
	} state_t;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
		adv = (p == PW'(SLOTS - 1)) ? '0 : PW'(p + PW'(1));
	endfunction

	state_t                state_q, state_d;
	logic [PW-1:0]         wp_q, wp_d;
	logic [PW-1:0]         old_q, old_d;
	logic [PW-1:0]         rptr_q [READERS];
	logic [PW-1:0]         rptr_d [READERS];
	logic [READERS-1:0]    used_q, used_d;
	logic [READERS-1:0]    endf_q, endf_d;
	logic                  eof_q, eof_d;
	logic [RW-1:0]         drain_q, drain_d;

	logic                  res_valid_q;
	logic [2:0]            status_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  last_q;
	logic [1:0]            slot_q;
	logic                  empty_q;
	logic [2:0]            count_q;
	logic                  over_q;

	logic                  load;
	logic [2:0]            n_status;
	logic [DATA_WIDTH-1:0] n_data;
	logic                  n_last;
	logic [1:0]            n_slot;
	logic                  n_empty;
	logic [2:0]            n_count;
	logic                  n_over;

	logic                  out_free;
	logic [PW-1:0]         wpn;
	logic [PW-1:0]         nxt;
	logic [RW-1:0]         sidx;
	logic                  sel_ok;
	logic [PW-1:0]         sel_ptr;
	logic                  free_found;
	logic [RW-1:0]         free_idx;

	always_comb begin
		state_d  = state_q;
		wp_d     = wp_q;
		old_d    = old_q;
		rptr_d   = rptr_q;
		used_d   = used_q;
		endf_d   = endf_q;
		eof_d    = eof_q;
		drain_d  = drain_q;

		pop       = 1'b0;
		load      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = head_data;
		ram_re    = 1'b0;
		ram_raddr = rptr_q[drain_q];

		n_status = mror_pkg::STAT_OK;
		n_data   = '0;
		n_last   = 1'b1;
		n_slot   = 2'd0;
		n_empty  = 1'b0;
		n_over   = 1'b0;

		out_free = !res_valid_q || !result_stall;
		wpn      = adv(wp_q);
		nxt      = adv(rptr_q[drain_q]);
		sidx     = head.cmd.slot_ok ? RW'(head.cmd.slot) : '0;
		sel_ok   = head.cmd.slot_ok && used_q[sidx];
		sel_ptr  = rptr_q[sidx];

		// lowest free reader slot
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = READERS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = RW'(i);
			end
		end

		case (state_q)
			S_IDLE: begin
				if (head.valid && out_free) begin
					pop  = 1'b1;
					load = 1'b1;
					case (head.cmd.kind)
						mror_pkg::K_WRITE: begin
							ram_we = 1'b1;
							wp_d   = wpn;
							for (int i = 0; i < READERS; i++) begin
								if (used_q[i] && rptr_q[i] == wpn) begin
									rptr_d[i] = adv(rptr_q[i]);
									n_over    = 1'b1;
								end
							end
							if (old_q == wpn) begin
								old_d  = adv(old_q);
								n_over = 1'b1;
							end
						end
						mror_pkg::K_READ: begin
							if (!sel_ok) begin
								n_status = mror_pkg::STAT_NOT_FND;
							end else if (endf_q[sidx]) begin
								n_status = mror_pkg::STAT_EOS;
							end else if (sel_ptr == wp_q) begin
								n_status = mror_pkg::STAT_NO_DATA;
							end else begin
								// fetch first word; results come from the drain state
								load      = 1'b0;
								ram_re    = 1'b1;
								ram_raddr = sel_ptr;
								drain_d   = sidx;
								state_d   = S_DRAIN;
							end
						end
						mror_pkg::K_ATTACH: begin
							if (free_found) begin
								used_d[free_idx] = 1'b1;
								rptr_d[free_idx] = old_q;
								endf_d[free_idx] = eof_q;
								n_slot           = 2'(free_idx);
							end else begin
								n_status = mror_pkg::STAT_NO_FREE;
							end
						end
						mror_pkg::K_DETACH: begin
							if (!sel_ok) begin
								n_status = mror_pkg::STAT_NOT_FND;
							end else begin
								used_d[sidx] = 1'b0;
								endf_d[sidx] = 1'b0;
								rptr_d[sidx] = '0;
							end
						end
						mror_pkg::K_EOF: begin
							eof_d  = 1'b1;
							endf_d = endf_q | used_q;
						end
						mror_pkg::K_QUERY: begin
							if (!sel_ok) begin
								n_status = mror_pkg::STAT_NOT_FND;
							end else begin
								n_empty = (sel_ptr == wp_q);
							end
						end
						default: ;
					endcase
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					load            = 1'b1;
					rptr_d[drain_q] = nxt;
					n_data          = ram_rdata;
					n_last          = (nxt == wp_q);
					if (n_last) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = nxt;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase

		n_count = 3'($countones(used_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			old_q       <= '0;
			for (int i = 0; i < READERS; i++) begin
				rptr_q[i] <= '0;
			end
			used_q      <= '0;
			endf_q      <= '0;
			eof_q       <= 1'b0;
			drain_q     <= '0;
			res_valid_q <= 1'b0;
			status_q    <= '0;
			data_q      <= '0;
			last_q      <= 1'b0;
			slot_q      <= '0;
			empty_q     <= 1'b0;
			count_q     <= '0;
			over_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			old_q   <= old_d;
			rptr_q  <= rptr_d;
			used_q  <= used_d;
			endf_q  <= endf_d;
			eof_q   <= eof_d;
			drain_q <= drain_d;
			if (load) begin
				res_valid_q <= 1'b1;
				status_q    <= n_status;
				data_q      <= n_data;
				last_q      <= n_last;
				slot_q      <= n_slot;
				empty_q     <= n_empty;
				count_q     <= n_count;
				over_q      <= n_over;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = res_valid_q;
	assign status        = status_q;
	assign read_data     = data_q;
	assign last          = last_q;
	assign assigned_slot = slot_q;
	assign is_empty      = empty_q;
	assign reader_count  = count_q;
	assign overrun       = over_q;

endmodule

[rtl/multi_reader_overwrite_ring_top.sv]
`timescale 1ns / 1ps

// channel   handshake                    payload
// item      item_valid / item_stall      operation, reader_slot, write_data
// result    result_valid / result_stall  status, read_data, last, assigned_slot,
//                                        is_empty, reader_count, overrun
//
// Items go through a two-word command queue to the execute stage, which takes one
// command per cycle while no read is draining and result_stall is low. Every command
// but a read with data gives one result. A read that drains N words first fetches the
// first word from the ring RAM (registered read), then gives one word per cycle while
// result_stall is low. Reset clears pointers, reader flags and the queue at once; ring
// contents stay undefined until written. item_stall is high while the queue is full;
// the result register holds under result_stall and the execute stage waits for it.
module multi_reader_overwrite_ring_top #(
	parameter int CAPACITY   = 15,
	parameter int READERS    = 4,
	parameter int DATA_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [2:0]            operation,
	input  logic [1:0]            reader_slot,
	input  logic [DATA_WIDTH-1:0] write_data,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [2:0]            status,
	output logic [DATA_WIDTH-1:0] read_data,
	output logic                  last,
	output logic [1:0]            assigned_slot,
	output logic                  is_empty,
	output logic [2:0]            reader_count,
	output logic                  overrun
);

	localparam int SLOTS = CAPACITY + 1;
	localparam int PW    = $clog2(SLOTS);

	mror_pkg::head_t       head;
	logic [DATA_WIDTH-1:0] head_data;
	logic                  pop;
	logic                  ram_we;
	logic [PW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [PW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	mror_front #(
		.READERS    (READERS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (operation),
		.reader_slot (reader_slot),
		.write_data  (write_data),
		.head        (head),
		.head_data   (head_data),
		.pop         (pop)
	);

	mror_back #(
		.CAPACITY   (CAPACITY),
		.READERS    (READERS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_data     (head_data),
		.pop           (pop),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.status        (status),
		.read_data     (read_data),
		.last          (last),
		.assigned_slot (assigned_slot),
		.is_empty      (is_empty),
		.reader_count  (reader_count),
		.overrun       (overrun)
	);

	mror_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ring writes only happen from idle, never during a drain
	a_ram_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ring written and read in the same cycle");

	a_pop_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("command popped from empty queue");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != mror_pkg::STAT_OK) |-> (last && read_data == '0))
		else $error("error result not a single word");

	a_write_overrun_only: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && overrun) |-> (status == mror_pkg::STAT_OK && last))
		else $error("overrun on a non-write result");

endmodule
